@@ hdl/rrma_pkg.sv @@
// Shared types and constants for the RGB running median with common range shift.
// No dependencies; compiled first.
package rrma_pkg;

  // Output level format
  localparam int LEVEL_BITS = 8;
  localparam int SHIFT_BITS = 2;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = 8'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd254;
  localparam logic [LEVEL_BITS-1:0] LEVEL_ALL_ONES = 8'hFF;

  // Compare flags a window cell shows to its neighbors
  typedef struct packed {
    logic lt;    // new sample is below this cell's value
    logic gt;    // new sample is above this cell's value
    logic zero;  // this cell holds the oldest entry
  } rrma_flags_t;

endpackage

@@ hdl/rrma_if.sv @@
// Handshake channels for the sample word and the level word.
// Depends on rrma_pkg for the level widths.
interface rrma_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] red_sample;
  logic [SAMPLE_BITS-1:0] green_sample;
  logic [SAMPLE_BITS-1:0] blue_sample;

  modport source (output valid, output red_sample, output green_sample,
                  output blue_sample, input ready);
  modport sink (input valid, input red_sample, input green_sample,
                input blue_sample, output ready);
endinterface

interface rrma_out_if;
  logic                             valid;
  logic                             ready;
  logic [rrma_pkg::LEVEL_BITS-1:0] red_level;
  logic [rrma_pkg::LEVEL_BITS-1:0] green_level;
  logic [rrma_pkg::LEVEL_BITS-1:0] blue_level;
  logic [rrma_pkg::SHIFT_BITS-1:0] range_shift;

  modport source (output valid, output red_level, output green_level,
                  output blue_level, output range_shift, input ready);
  modport sink (input valid, input red_level, input green_level,
                input blue_level, input range_shift, output ready);
endinterface

@@ hdl/rrma_cell.sv @@
// One slot of a sorted window: value, age and the insert decision for this slot.
// Depends on rrma_pkg for the neighbor flag struct.
module rrma_cell #(
  parameter int SAMPLE_BITS = 10,
  parameter int AGE_BITS    = 4,
  parameter int INIT_AGE    = 0,
  parameter int TOP_AGE     = 8,
  parameter bit FIRST       = 1'b0,
  parameter bit LAST        = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   claim_pos,   // take the drop slot when no entry is oldest
  input  logic                   below_in,    // drop slot lies at a lower index
  output logic                   below_out,
  input  logic [SAMPLE_BITS-1:0] lo_val,
  input  logic [AGE_BITS-1:0]    lo_age,
  input  rrma_pkg::rrma_flags_t  lo_flags,
  input  logic [SAMPLE_BITS-1:0] hi_val,
  input  logic [AGE_BITS-1:0]    hi_age,
  input  rrma_pkg::rrma_flags_t  hi_flags,
  output logic [SAMPLE_BITS-1:0] val,
  output logic [AGE_BITS-1:0]    age,
  output rrma_pkg::rrma_flags_t  flags
);
  import rrma_pkg::*;

  localparam logic [AGE_BITS-1:0] AGE_TOP  = AGE_BITS'(TOP_AGE);
  localparam logic [AGE_BITS-1:0] AGE_INIT = AGE_BITS'(INIT_AGE);
  localparam logic [AGE_BITS-1:0] AGE_ONE  = AGE_BITS'(1);

  logic [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic [AGE_BITS-1:0]    age_r, age_nxt;
  logic                   is_pos;
  logic                   take_lo, take_hi;

  // compare against the incoming sample
  assign flags.lt   = sample < val_r;
  assign flags.gt   = sample > val_r;
  assign flags.zero = (age_r == '0);

  assign is_pos    = flags.zero | claim_pos;
  assign below_out = below_in | is_pos;

  assign take_lo = !FIRST && lo_flags.lt;
  assign take_hi = !LAST && hi_flags.gt;

  // pick the new slot content: shift from a neighbor, take the sample or hold
  always_comb begin
    val_nxt = val_r;
    age_nxt = (age_r != '0) ? age_r - AGE_ONE : '0;
    if (!below_in && !is_pos) begin
      if (take_lo) begin
        val_nxt = lo_val;
        age_nxt = lo_age - AGE_ONE;
      end else if (flags.lt) begin
        val_nxt = sample;
        age_nxt = AGE_TOP;
      end
    end else if (!below_in) begin
      if (take_lo) begin
        val_nxt = lo_val;
        age_nxt = lo_age - AGE_ONE;
      end else if (take_hi) begin
        val_nxt = hi_val;
        age_nxt = hi_age - AGE_ONE;
      end else begin
        val_nxt = sample;
        age_nxt = AGE_TOP;
      end
    end else begin
      if (take_hi) begin
        val_nxt = hi_val;
        age_nxt = hi_age - AGE_ONE;
      end else if (flags.gt) begin
        val_nxt = sample;
        age_nxt = AGE_TOP;
      end
    end
  end

  // update on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= AGE_INIT;
    end else if (load) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val = val_r;
  assign age = age_r;

endmodule

@@ hdl/rrma_row.sv @@
// One color channel: a chain of window cells kept in ascending order.
// Depends on rrma_pkg and rrma_cell.
module rrma_row #(
  parameter int WINDOW_SIZE = 9,
  parameter int SAMPLE_BITS = 10,
  parameter int AGE_BITS    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] median
);
  import rrma_pkg::*;

  logic [SAMPLE_BITS-1:0] val   [WINDOW_SIZE];
  logic [AGE_BITS-1:0]    age   [WINDOW_SIZE];
  rrma_flags_t            flags [WINDOW_SIZE];
  logic [WINDOW_SIZE:0]   below;
  logic [WINDOW_SIZE-1:0] zeros;
  logic                   none_old;

  // fall back to the first slot when no entry is oldest
  assign none_old = ~|zeros;
  assign below[0] = 1'b0;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic [AGE_BITS-1:0]    lo_age, hi_age;
    rrma_flags_t            lo_flags, hi_flags;

    assign zeros[i] = flags[i].zero;

    if (i == 0) begin : g_lo_edge
      assign lo_val   = '0;
      assign lo_age   = '0;
      assign lo_flags = '0;
    end else begin : g_lo
      assign lo_val   = val[i-1];
      assign lo_age   = age[i-1];
      assign lo_flags = flags[i-1];
    end

    if (i == WINDOW_SIZE-1) begin : g_hi_edge
      assign hi_val   = '0;
      assign hi_age   = '0;
      assign hi_flags = '0;
    end else begin : g_hi
      assign hi_val   = val[i+1];
      assign hi_age   = age[i+1];
      assign hi_flags = flags[i+1];
    end

    rrma_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS),
      .INIT_AGE    (WINDOW_SIZE-1-i),
      .TOP_AGE     (WINDOW_SIZE-1),
      .FIRST       (i == 0),
      .LAST        (i == WINDOW_SIZE-1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (load),
      .sample    (sample),
      .claim_pos ((i == 0) ? none_old : 1'b0),
      .below_in  (below[i]),
      .below_out (below[i+1]),
      .lo_val    (lo_val),
      .lo_age    (lo_age),
      .lo_flags  (lo_flags),
      .hi_val    (hi_val),
      .hi_age    (hi_age),
      .hi_flags  (hi_flags),
      .val       (val[i]),
      .age       (age[i]),
      .flags     (flags[i])
    );
  end

  assign median = val[WINDOW_SIZE/2];

endmodule

@@ hdl/rrma_scale.sv @@
// Common range shift of the three medians and clamp to the 8-bit level range.
// Depends on rrma_pkg for level widths and limits.
module rrma_scale #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic [SAMPLE_BITS-1:0]          red_med,
  input  logic [SAMPLE_BITS-1:0]          green_med,
  input  logic [SAMPLE_BITS-1:0]          blue_med,
  output logic [rrma_pkg::LEVEL_BITS-1:0] red_level,
  output logic [rrma_pkg::LEVEL_BITS-1:0] green_level,
  output logic [rrma_pkg::LEVEL_BITS-1:0] blue_level,
  output logic [rrma_pkg::SHIFT_BITS-1:0] range_shift
);
  import rrma_pkg::*;

  localparam int SHW = $clog2(SAMPLE_BITS - LEVEL_BITS + 2);

  logic [SAMPLE_BITS-1:0] orv;
  logic [SHW-1:0]         shift;

  function automatic logic [LEVEL_BITS-1:0] clamp_level(
    input logic [SAMPLE_BITS-1:0] med,
    input logic [SHW-1:0]         sh
  );
    logic [SAMPLE_BITS-1:0] shifted;
    logic [LEVEL_BITS-1:0]  lvl;
    shifted = med >> sh;
    lvl     = shifted[LEVEL_BITS-1:0];
    if (lvl == '0) begin
      lvl = LEVEL_MIN;
    end else if (lvl == LEVEL_ALL_ONES) begin
      lvl = LEVEL_MAX;
    end
    return lvl;
  endfunction

  // shift by the number of bits the OR of the medians spills past a level
  always_comb begin
    orv   = red_med | green_med | blue_med;
    shift = '0;
    for (int b = LEVEL_BITS; b < SAMPLE_BITS; b++) begin
      if (orv[b]) begin
        shift = SHW'(b - LEVEL_BITS + 1);
      end
    end
  end

  assign red_level   = clamp_level(red_med, shift);
  assign green_level = clamp_level(green_med, shift);
  assign blue_level  = clamp_level(blue_med, shift);
  assign range_shift = shift[SHIFT_BITS-1:0];

endmodule

@@ hdl/rgb_running_median_autorange.sv @@
// Top level: three running-median windows, range shift and the output register.
// Depends on rrma_pkg, rrma_if, rrma_row and rrma_scale.
//
// Each accepted sample word is sorted into three windows of WINDOW_SIZE cells
// (one row of cells per color) in the cycle it is taken; the scale state then
// scales the three medians with one common right shift and loads the output
// register once that register is free. No new word is taken until the scale
// state has loaded its result: the insert in the cell chain comes first, then
// the scale step. The output register lets the next word be taken while a
// result still waits; a second result waits in the scale step until the
// register drains. After reset every window holds zeros, oldest entry last.
module rgb_running_median_autorange #(
  parameter int WINDOW_SIZE = 9,
  parameter int SAMPLE_BITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  rrma_in_if.sink       in_bus,
  rrma_out_if.source    out_bus
);
  import rrma_pkg::*;

  localparam int AGE_BITS = $clog2(WINDOW_SIZE);

  typedef enum logic {
    ST_IDLE,
    ST_SCALE
  } state_t;

  state_t                 state_r;
  logic                   load;
  logic                   out_free;
  logic                   load_out;
  logic [SAMPLE_BITS-1:0] red_med, green_med, blue_med;
  logic [LEVEL_BITS-1:0]  red_lvl, green_lvl, blue_lvl;
  logic [SHIFT_BITS-1:0]  shift_w;

  logic                   out_valid_r;
  logic [LEVEL_BITS-1:0]  red_level_r, green_level_r, blue_level_r;
  logic [SHIFT_BITS-1:0]  range_shift_r;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign load         = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign load_out     = (state_r == ST_SCALE) && out_free;

  // sorted windows, one per color
  rrma_row #(.WINDOW_SIZE(WINDOW_SIZE), .SAMPLE_BITS(SAMPLE_BITS), .AGE_BITS(AGE_BITS))
    u_red (.clk(clk), .rst_n(rst_n), .load(load), .sample(in_bus.red_sample),
           .median(red_med));
  rrma_row #(.WINDOW_SIZE(WINDOW_SIZE), .SAMPLE_BITS(SAMPLE_BITS), .AGE_BITS(AGE_BITS))
    u_green (.clk(clk), .rst_n(rst_n), .load(load), .sample(in_bus.green_sample),
             .median(green_med));
  rrma_row #(.WINDOW_SIZE(WINDOW_SIZE), .SAMPLE_BITS(SAMPLE_BITS), .AGE_BITS(AGE_BITS))
    u_blue (.clk(clk), .rst_n(rst_n), .load(load), .sample(in_bus.blue_sample),
            .median(blue_med));

  rrma_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
    .red_med     (red_med),
    .green_med   (green_med),
    .blue_med    (blue_med),
    .red_level   (red_lvl),
    .green_level (green_lvl),
    .blue_level  (blue_lvl),
    .range_shift (shift_w)
  );

  // sequence: insert, then scale into the output register when it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (load) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (load_out) begin
            red_level_r   <= red_lvl;
            green_level_r <= green_lvl;
            blue_level_r  <= blue_lvl;
            range_shift_r <= shift_w;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.red_level   = red_level_r;
  assign out_bus.green_level = green_level_r;
  assign out_bus.blue_level  = blue_level_r;
  assign out_bus.range_shift = range_shift_r;

endmodule

@@ tb/sv/rgb_running_median_autorange_tb.sv @@
// Self-checking testbench for rgb_running_median_autorange: three 9-entry running
// median windows, one shared range shift, levels clamped to 1..254.
// Depends on rrma_pkg, rrma_if and the block's RTL; reads no files.
module rgb_running_median_autorange_tb;
  import rrma_pkg::*;

  localparam int WINDOW     = 9;
  localparam int SAMPLE_W   = 10;
  localparam int MEDIAN_IDX = WINDOW / 2;
  localparam int COLORS     = 3;
  localparam int IDLE_LIMIT = 2000;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] red;
    logic [LEVEL_BITS-1:0] green;
    logic [LEVEL_BITS-1:0] blue;
    logic [SHIFT_BITS-1:0] shift;
  } level_word_t;

  logic clk;
  logic rst_n;

  rrma_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_bus ();
  rrma_out_if out_bus ();

  rgb_running_median_autorange #(
    .WINDOW_SIZE(WINDOW),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  // Predictor state: sorted window values and ages per color
  sample_t win_value [COLORS][WINDOW];
  int      win_age   [COLORS][WINDOW];
  int      drift_center [COLORS];
  sample_t last_sample  [COLORS];

  level_word_t pending_levels[$];
  level_word_t got_word;
  level_word_t exp_word;

  int src_idle_pct;
  int sink_stall_pct;
  int error_count;
  int words_sent;
  int words_checked;
  int shift_seen [3];
  int idle_cycles;

  // Clock and receiver back-pressure
  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic int order_of(sample_t a, sample_t b);
    if (a < b) return -1;
    if (a > b) return 1;
    return 0;
  endfunction

  function automatic void clear_windows();
    int ch;
    int k;
    for (ch = 0; ch < COLORS; ch++) begin
      for (k = 0; k < WINDOW; k++) begin
        win_value[ch][k] = '0;
        win_age[ch][k]   = WINDOW - 1 - k;
      end
    end
  endfunction

  // Drop the oldest entry, age the rest, and slide the new sample into order
  function automatic void sort_into_window(int ch, sample_t s);
    int  pos;
    int  dir;
    int  stop;
    int  nb;
    int  k;
    bit  moving;
    pos = 0;
    for (k = 0; k < WINDOW; k++) begin
      if (win_age[ch][k] != 0) win_age[ch][k]--;
      else pos = k;
    end
    dir = order_of(s, win_value[ch][pos]);
    if (dir != 0) begin
      stop   = (dir < 0) ? 0 : WINDOW - 1;
      moving = 1'b1;
      while (moving && pos != stop) begin
        nb = pos + dir;
        if (order_of(s, win_value[ch][nb]) != dir) begin
          moving = 1'b0;
        end else begin
          win_value[ch][pos] = win_value[ch][nb];
          win_age[ch][pos]   = win_age[ch][nb];
          pos = nb;
        end
      end
    end
    win_value[ch][pos] = s;
    win_age[ch][pos]   = WINDOW - 1;
  endfunction

  // Advance all three windows and scale the medians by one common shift
  function automatic level_word_t predict_levels(sample_t r, sample_t g, sample_t b);
    sample_t               med [COLORS];
    sample_t               orv;
    sample_t               scaled;
    logic [31:0]           shift;
    int                    width;
    int                    ch;
    int                    bi;
    logic [LEVEL_BITS-1:0] lvl [COLORS];
    level_word_t           w;
    sort_into_window(0, r);
    sort_into_window(1, g);
    sort_into_window(2, b);
    orv = '0;
    for (ch = 0; ch < COLORS; ch++) begin
      med[ch] = win_value[ch][MEDIAN_IDX];
      orv = orv | med[ch];
    end
    width = 0;
    for (bi = 0; bi < SAMPLE_W; bi++) if (orv[bi]) width = bi + 1;
    shift = (width > LEVEL_BITS) ? width - LEVEL_BITS : 0;
    for (ch = 0; ch < COLORS; ch++) begin
      scaled  = med[ch] >> shift;
      lvl[ch] = scaled[LEVEL_BITS-1:0];
      if (lvl[ch] == '0) lvl[ch] = LEVEL_MIN;
      else if (lvl[ch] == LEVEL_ALL_ONES) lvl[ch] = LEVEL_MAX;
    end
    w.red   = lvl[0];
    w.green = lvl[1];
    w.blue  = lvl[2];
    w.shift = shift[SHIFT_BITS-1:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("[%0t] mismatch on %s in level word %0d: got %0d, want %0d",
             $realtime, what, words_checked, got, want);
  endtask

  // Check each accepted level word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got_word.red   = out_bus.red_level;
      got_word.green = out_bus.green_level;
      got_word.blue  = out_bus.blue_level;
      got_word.shift = out_bus.range_shift;
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected word", int'(got_word), 0);
      end else begin
        exp_word = pending_levels.pop_front();
        if (got_word.red !== exp_word.red)
          report_mismatch("red_level", int'(got_word.red), int'(exp_word.red));
        if (got_word.green !== exp_word.green)
          report_mismatch("green_level", int'(got_word.green), int'(exp_word.green));
        if (got_word.blue !== exp_word.blue)
          report_mismatch("blue_level", int'(got_word.blue), int'(exp_word.blue));
        if (got_word.shift !== exp_word.shift)
          report_mismatch("range_shift", int'(got_word.shift), int'(exp_word.shift));
        if (exp_word.shift < 3) shift_seen[exp_word.shift]++;
      end
      words_checked++;
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d predictions pending",
                 IDLE_LIMIT, pending_levels.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Send one sample word, with random gaps ahead of it; valid stays high after
  task automatic send_word(sample_t r, sample_t g, sample_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid        <= 1'b1;
    in_bus.red_sample   <= r;
    in_bus.green_sample <= g;
    in_bus.blue_sample  <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_levels.push_back(predict_levels(r, g, b));
    words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  // Hold the sender until every predicted word has come back
  task automatic drain_levels();
    release_input();
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // Random sample: mostly drifting around a slowly moving center, plus noise
  function automatic sample_t pick_sample(int ch);
    int v;
    if ($urandom_range(49) == 0) drift_center[ch] = $urandom_range(1023);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        drift_center[ch] += $urandom_range(40) - 20;
        if (drift_center[ch] < 0) drift_center[ch] = 0;
        if (drift_center[ch] > 1023) drift_center[ch] = 1023;
        v = drift_center[ch] + $urandom_range(16) - 8;
      end
      4: v = $urandom_range(1023);
      5: v = $urandom_range(1) ? 1023 : 0;
      6: begin
        case ($urandom_range(7))
          0: v = 254;
          1: v = 255;
          2: v = 256;
          3: v = 257;
          4: v = 510;
          5: v = 511;
          6: v = 512;
          default: v = 513;
        endcase
      end
      7: v = last_sample[ch];
      default: v = $urandom_range(300);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    last_sample[ch] = v[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  // Repeats of the dropped value, full-scale medians, and the shift boundaries
  task automatic test_equal_and_saturation();
    send_word(10'd0, 10'd0, 10'd0);
    repeat (5) send_word(10'd1023, 10'd1023, 10'd1023);
    repeat (5) send_word(10'd255, 10'd256, 10'd511);
  endtask

  // Walk a single one through every sample bit on each color, then alternating bits
  task automatic test_walking_bits();
    int i;
    for (i = 0; i < SAMPLE_W; i++) begin
      send_word(sample_t'(1) << i, sample_t'(1) << ((i + 3) % SAMPLE_W),
                sample_t'(1) << ((i + 7) % SAMPLE_W));
    end
    send_word(10'h155, 10'h2AA, 10'h155);
    send_word(10'h2AA, 10'h155, 10'h2AA);
  endtask

  task automatic test_random_traffic(int count, int src_pct, int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_word(pick_sample(0), pick_sample(1), pick_sample(2));
  endtask

  // Pause the sender mid-stream until the block has fully drained
  task automatic test_drain_pause();
    test_random_traffic(100, 38, 38);
    drain_levels();
    test_random_traffic(100, 38, 38);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.red_sample   = '0;
    in_bus.green_sample = '0;
    in_bus.blue_sample  = '0;
    out_bus.ready       = 1'b0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    error_count         = 0;
    words_sent          = 0;
    words_checked       = 0;
    idle_cycles         = 0;
    shift_seen          = '{0, 0, 0};
    drift_center        = '{200, 400, 700};
    last_sample         = '{10'd0, 10'd0, 10'd0};
    clear_windows();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_equal_and_saturation();
    test_walking_bits();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 52, 0);
    test_random_traffic(200, 0, 52);
    test_drain_pause();

    // Wait out the last predictions, then the pipeline depth
    release_input();
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d sample words and checked %0d level words across four idle mixes.",
             words_sent, words_checked);
    $display("Range shift 0/1/2 seen %0d/%0d/%0d times; %0d mismatches.",
             shift_seen[0], shift_seen[1], shift_seen[2], error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
